@@ sv/rrrs_pkg.sv @@
// rrrs_pkg: command codes, widths and controller/datapath structs
// for the rotatable reversible ring store; no dependencies
package rrrs_pkg;

  localparam logic [2:0] CMD_READ    = 3'd0;
  localparam logic [2:0] CMD_WRITE   = 3'd1;
  localparam logic [2:0] CMD_ROTATE  = 3'd2;
  localparam logic [2:0] CMD_TOGGLE  = 3'd3;
  localparam logic [2:0] CMD_ZERO    = 3'd4;
  localparam logic [2:0] CMD_SORT    = 3'd5;

  localparam int unsigned CmdWidth  = 3;
  localparam int unsigned IdxWidth  = 16;
  localparam int unsigned ValWidth  = 32;
  localparam int unsigned OrgWidth  = 8;
  localparam int unsigned LenWidth  = 9;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture sum sign and magnitude, start mod
    logic mod_step;   // one restoring division step
    logic mem_read;   // read mapped slot
    logic mem_write;  // write mapped slot
    logic set_origin; // origin <- mapped slot
    logic toggle;
    logic zero_org;
    logic sort_init;  // a <- 1, b <- 1
    logic sort_rd;    // read store[b-1] into rdata
    logic sort_cmp;   // compare / shift step
    logic sort_next;  // place key, advance a
    logic sort_key;   // load key from store[a]
    logic out_load;
  } ctl_t;

  typedef struct packed {
    logic mod_done;
    logic sort_done;  // a >= len
    logic shift_more; // b > 0 and store[b-1] > key
  } sts_t;

endpackage

@@ sv/rrrs_datapath.sv @@
// rrrs_datapath: element memory, origin/direction registers, serial modulo
// and insertion-sort pointers; depends on rrrs_pkg
module rrrs_datapath #(
  parameter int unsigned DEPTH      = 256,
  parameter int unsigned ELEM_WIDTH = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  rrrs_pkg::ctl_t                 ctl_i,
  output rrrs_pkg::sts_t                 sts_o,
  input  logic [rrrs_pkg::LenWidth-1:0]  len_cfg_i,
  input  logic [rrrs_pkg::IdxWidth-1:0]  idx_i,
  input  logic [rrrs_pkg::ValWidth-1:0]  wval_i,
  input  logic [rrrs_pkg::CmdWidth-1:0]  cmd_i,
  output logic [rrrs_pkg::ValWidth+rrrs_pkg::OrgWidth:0] res_o
);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned LW = $clog2(DEPTH + 1);
  localparam int unsigned NW = 19; // signed sum width
  localparam int unsigned CW = $clog2(NW + 1);

  logic [ELEM_WIDTH-1:0] mem [DEPTH];
  logic [ELEM_WIDTH-1:0] rdata_q, key_q;
  logic [AW-1:0] origin_q;
  logic          rev_q;
  logic [LW-1:0] len;
  logic [rrrs_pkg::LenWidth-1:0] lc;

  // effective length clamp
  always_comb begin
    lc = len_cfg_i;
    if (lc == '0) len = LW'(1);
    else if (32'(lc) > DEPTH) len = LW'(DEPTH);
    else len = LW'(lc);
  end

  // restoring modulo of |sum| by len, one bit per cycle
  logic [NW-1:0] mag_q, rem_q;
  logic          neg_q;
  logic [CW-1:0] cnt_q;
  logic signed [NW-1:0] sum;
  logic signed [NW-1:0] ix;
  logic [NW-1:0] trial;
  logic [AW-1:0] slot;
  always_comb begin
    ix = NW'($signed(idx_i));
    if (cmd_i == rrrs_pkg::CMD_SORT) ix = '0;
    if (rev_q) ix = -ix - NW'(1);
    sum = $signed({{(NW-AW){1'b0}}, origin_q}) + ix;
    trial = {rem_q[NW-2:0], mag_q[NW-1]};
    if (rem_q == '0) slot = '0;
    else if (neg_q) slot = AW'(NW'(len) - rem_q);
    else slot = AW'(rem_q);
  end
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      neg_q <= sum[NW-1];
      mag_q <= sum[NW-1] ? NW'(-sum) : NW'(sum);
      rem_q <= '0;
      cnt_q <= '0;
    end else if (ctl_i.mod_step) begin
      mag_q <= {mag_q[NW-2:0], 1'b0};
      rem_q <= (trial >= NW'(len)) ? trial - NW'(len) : trial;
      cnt_q <= cnt_q + CW'(1);
    end
  end
  assign sts_o.mod_done = (cnt_q == CW'(NW));

  // sort pointers
  logic [LW-1:0] a_q, b_q;
  logic [AW-1:0] bm1;
  logic [ELEM_WIDTH-1:0] flip;
  assign bm1 = AW'(b_q - LW'(1));
  assign flip = ELEM_WIDTH'(1) << (ELEM_WIDTH - 1);
  assign sts_o.sort_done = (a_q >= len);
  assign sts_o.shift_more = (b_q != '0) && ((rdata_q ^ flip) > (key_q ^ flip));

  always_ff @(posedge clk_i) begin
    if (ctl_i.mem_read) rdata_q <= mem[slot];
    else if (ctl_i.sort_key) key_q <= mem[AW'(a_q)];
    else if (ctl_i.sort_rd) rdata_q <= mem[bm1];
    if (ctl_i.mem_write) mem[slot] <= ELEM_WIDTH'($signed(wval_i));
    else if (ctl_i.sort_cmp && sts_o.shift_more) mem[AW'(b_q)] <= rdata_q;
    else if (ctl_i.sort_next) mem[AW'(b_q)] <= key_q;
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.sort_init) begin
      a_q <= LW'(1);
      b_q <= LW'(1);
    end else if (ctl_i.sort_cmp && sts_o.shift_more) begin
      b_q <= b_q - LW'(1);
    end else if (ctl_i.sort_next) begin
      a_q <= a_q + LW'(1);
      b_q <= a_q + LW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_q <= '0;
      rev_q    <= 1'b0;
    end else begin
      if (ctl_i.set_origin) origin_q <= slot;
      if (ctl_i.zero_org)   origin_q <= '0;
      if (ctl_i.toggle)     rev_q <= ~rev_q;
    end
  end

  // result word: read value, origin, direction
  logic [rrrs_pkg::ValWidth-1:0] rv;
  always_comb begin
    rv = '0;
    if (cmd_i == rrrs_pkg::CMD_READ)
      rv = rrrs_pkg::ValWidth'($signed(rdata_q));
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.out_load) begin
      res_o <= {rev_q, rrrs_pkg::OrgWidth'(origin_q), rv};
    end
  end
endmodule

@@ sv/rrrs_ctrl.sv @@
// rrrs_ctrl: sequencer for command decode, modulo, memory access and sort
// depends on rrrs_pkg
module rrrs_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [rrrs_pkg::CmdWidth-1:0] cmd_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output rrrs_pkg::ctl_t                ctl_o,
  input  rrrs_pkg::sts_t                sts_i
);
  localparam logic [3:0] S_IDLE = 4'd0, S_MOD = 4'd1, S_ACT = 4'd2, S_RES = 4'd3,
                         S_OUT = 4'd4, S_SKEY = 4'd5, S_SRD = 4'd6, S_SCMP = 4'd7,
                         S_SMAP = 4'd8, S_SMOD = 4'd9, S_SCHK = 4'd10;
  logic [3:0] st_q, st_d;
  logic       ov_q, ov_d;

  assign in_ready_o  = (st_q == S_IDLE) && !ov_q;
  assign out_valid_o = ov_q;

  always_comb begin
    st_d  = st_q;
    ov_d  = ov_q && !out_ready_i;
    ctl_o = '0;
    case (st_q)
      S_IDLE: if (in_valid_i && in_ready_o) begin
        if (cmd_i == rrrs_pkg::CMD_SORT) begin
          ctl_o.sort_init = 1'b1;
          st_d = S_SCHK;
        end else begin
          ctl_o.load = 1'b1;
          st_d = S_MOD;
        end
      end
      S_MOD: begin
        if (sts_i.mod_done) st_d = S_ACT;
        else ctl_o.mod_step = 1'b1;
      end
      S_ACT: begin
        case (cmd_i)
          rrrs_pkg::CMD_READ:   ctl_o.mem_read = 1'b1;
          rrrs_pkg::CMD_WRITE:  ctl_o.mem_write = 1'b1;
          rrrs_pkg::CMD_ROTATE,
          rrrs_pkg::CMD_SORT:   ctl_o.set_origin = 1'b1;
          rrrs_pkg::CMD_TOGGLE: ctl_o.toggle = 1'b1;
          rrrs_pkg::CMD_ZERO:   ctl_o.zero_org = 1'b1;
          default: ;
        endcase
        st_d = S_RES;
      end
      S_RES: begin
        ctl_o.out_load = 1'b1;
        st_d = S_OUT;
      end
      S_OUT: begin
        ov_d = 1'b1;
        st_d = S_IDLE;
      end
      S_SCHK: begin
        if (sts_i.sort_done) st_d = S_SMAP;
        else begin
          ctl_o.sort_key = 1'b1;
          st_d = S_SRD;
        end
      end
      S_SKEY: st_d = S_SRD;
      S_SRD: begin
        ctl_o.sort_rd = 1'b1;
        st_d = S_SCMP;
      end
      S_SCMP: begin
        ctl_o.sort_cmp = 1'b1;
        if (sts_i.shift_more) st_d = S_SRD;
        else begin
          ctl_o.sort_cmp = 1'b0;
          ctl_o.sort_next = 1'b1;
          st_d = S_SCHK;
        end
      end
      S_SMAP: begin
        ctl_o.load = 1'b1;
        st_d = S_MOD;
      end
      S_SMOD: st_d = S_MOD;
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
      ov_q <= 1'b0;
    end else begin
      st_q <= st_d;
      ov_q <= ov_d;
    end
  end
endmodule

@@ sv/rotatable_reversible_ring_store_unit.sv @@
// rotatable_reversible_ring_store_unit: top level of the ring store
// instantiates rrrs_ctrl and rrrs_datapath; depends on rrrs_pkg
//
// One command word at a time. Read, write, rotate, toggle and origin-to-zero
// fold the index into a slot by a one-bit-per-cycle restoring modulo over a
// 19-bit signed sum, then do the memory access and result staging. Sort is an
// in-place insertion sort over the active length, then the origin remap.
// The result word is held until taken; the next command is accepted then.
module rotatable_reversible_ring_store_unit #(
  parameter int unsigned DEPTH      = 256,
  parameter int unsigned ELEM_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // logical_index[15:0], write_value[47:16]
  input  logic [2:0]  s_axis_tuser,  // command[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // read_value[31:0], current_origin[39:32], is_reversed[40]
  input  logic        cfg_we_i,
  input  logic [8:0]  cfg_wdata_i
);
  rrrs_pkg::ctl_t ctl;
  rrrs_pkg::sts_t sts;
  logic [8:0]  len_q;
  logic [2:0]  cmd_q;
  logic [15:0] idx_q;
  logic [31:0] wv_q;
  logic [40:0] res;
  logic        acc;

  assign acc = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) len_q <= rrrs_pkg::LenWidth'(DEPTH);
    else if (cfg_we_i) len_q <= cfg_wdata_i;
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      cmd_q <= s_axis_tuser;
      idx_q <= s_axis_tdata[15:0];
      wv_q  <= s_axis_tdata[47:16];
    end
  end

  // sum is formed from the live word during acceptance, then held
  logic [2:0]  cmd_m;
  logic [15:0] idx_m;
  assign cmd_m = acc ? s_axis_tuser : cmd_q;
  assign idx_m = acc ? s_axis_tdata[15:0] : idx_q;

  rrrs_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .cmd_i      (cmd_m),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .ctl_o      (ctl),
    .sts_i      (sts)
  );

  rrrs_datapath #(.DEPTH(DEPTH), .ELEM_WIDTH(ELEM_WIDTH)) u_dp (
    .clk_i, .rst_ni,
    .ctl_i     (ctl),
    .sts_o     (sts),
    .len_cfg_i (len_q),
    .idx_i     (idx_m),
    .wval_i    (wv_q),
    .cmd_i     (cmd_m),
    .res_o     (res)
  );

  assign m_axis_tdata = {7'd0, res};
endmodule
